/* hw/rtl/assert_macros.svh */
// Assertion macros used by the request sequencer of the ordered unique key queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hw/rtl/oukq_pkg.sv */
// Package with the constants, codes and types of the ordered unique key queue.
package oukq_pkg;

    // Queue depth and derived widths.
    localparam int DEPTH    = 16;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(DEPTH + 1);

    // Field widths of the request and result transfers.
    localparam int PID_W    = 32;
    localparam int MODE_W   = 3;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Common width for comparing a position against the count.
    localparam int PW       = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_POP    = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_READ   = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INS_SHIFT,
        S_REM_SHIFT,
        S_PUT,
        S_READ,
        S_READ_WAIT,
        S_RESP
    } state_t;

    typedef struct packed {
        status_t              status;
        logic [PID_W-1:0]     pid_out;
        logic [COUNT_W-1:0]   count;
    } result_t;

endpackage

/* hw/rtl/oukq_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
module oukq_ram #(
    parameter int DEPTH = 16,
    parameter int DW    = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port: the data appears in the cycle after the read.
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/oukq_ctrl.sv */
// Request sequencer: searches, shifts and updates the queue held in the entry RAM.
`include "assert_macros.svh"
module oukq_ctrl
    import oukq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [MODE_W-1:0]  s_mode,
    input  logic [PID_W-1:0]   s_pid,
    input  logic [PID_W-1:0]   s_anchor_pid,
    input  logic [POS_W-1:0]   s_position,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  logic [PID_W-1:0]   rd_data,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [PID_W-1:0]   wr_data
);

    state_t             state_reg, state_next;
    logic [CW-1:0]      occ_reg, occ_next;
    logic [CW-1:0]      iss_reg, iss_next;
    logic               rd_vld_reg;
    logic [CW-1:0]      rd_idx_reg;

    logic [MODE_W-1:0]  mode_reg;
    logic [PID_W-1:0]   pid_reg;
    logic [PID_W-1:0]   anchor_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      put_idx_reg, put_idx_next;
    logic               hit_reg, hit_next;
    logic [CW-1:0]      hit_idx_reg, hit_idx_next;
    logic               anc_reg, anc_next;
    logic [CW-1:0]      anc_idx_reg, anc_idx_next;
    status_t            status_reg, status_next;
    logic [PID_W-1:0]   pid_out_reg, pid_out_next;

    logic               accept;
    logic               is_empty;
    logic               is_full;
    logic               pos_bad;
    logic               iss_go;
    logic               walk_done;
    logic [CW-1:0]      iss_addr;
    logic [CW-1:0]      rd_idx_inc;
    logic [CW-1:0]      rd_idx_dec;
    logic [CW-1:0]      anc_idx_inc;
    logic [PW-1:0]      pos_ext;
    status_t            acc_status;
    status_t            scan_status;
    logic               scan_pass;

    // Simple conditions on the stored count and the request.
    assign accept      = s_valid && s_ready;
    assign is_empty    = (occ_reg == '0);
    assign is_full     = (occ_reg >= CW'(DEPTH));
    assign pos_bad     = (PW'(s_position) >= PW'(occ_reg));
    assign pos_ext     = PW'(pos_reg);
    assign rd_idx_inc  = rd_idx_reg + CW'(1);
    assign rd_idx_dec  = rd_idx_reg - CW'(1);
    assign anc_idx_inc = anc_idx_reg + CW'(1);

    // Read issue for the walking states: upward for search and removal,
    // downward for the make-room shift of an insert.
    always_comb begin
        iss_go   = 1'b0;
        iss_addr = iss_reg;
        unique case (state_reg)
            S_SCAN, S_REM_SHIFT: begin
                iss_go = (iss_reg < occ_reg);
            end
            S_INS_SHIFT: begin
                iss_go   = (iss_reg > lo_reg);
                iss_addr = iss_reg - CW'(1);
            end
            default: begin
            end
        endcase
    end

    // A walk is over once nothing is issued and the read pipeline is empty.
    assign walk_done = !iss_go && !rd_vld_reg;

    // Status of a request that is answered without touching the RAM.
    always_comb begin
        acc_status = ST_NOTFOUND;
        unique case (s_mode)
            MODE_INSERT, MODE_POP, MODE_REMOVE: begin
                if (is_empty) begin
                    acc_status = ST_EMPTY;
                end
            end
            MODE_READ: begin
                priority if (is_empty) begin
                    acc_status = ST_EMPTY;
                end else if (pos_bad) begin
                    acc_status = ST_NOTFOUND;
                end
            end
            default: begin
                acc_status = ST_NOTFOUND;
            end
        endcase
    end

    // Verdict after the search pass; order of the checks follows priority.
    always_comb begin
        scan_pass   = 1'b0;
        scan_status = ST_NOTFOUND;
        unique case (mode_reg)
            MODE_APPEND: begin
                priority if (hit_reg) begin
                    scan_status = ST_DUP;
                end else if (is_full) begin
                    scan_status = ST_FULL;
                end else begin
                    scan_pass = 1'b1;
                end
            end
            MODE_INSERT: begin
                priority if (hit_reg) begin
                    scan_status = ST_DUP;
                end else if (!anc_reg) begin
                    scan_status = ST_NOTFOUND;
                end else if (is_full) begin
                    scan_status = ST_FULL;
                end else begin
                    scan_pass = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (hit_reg) begin
                    scan_pass = 1'b1;
                end
            end
            default: begin
                scan_status = ST_NOTFOUND;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_mode)
                        MODE_APPEND: state_next = S_SCAN;
                        MODE_INSERT, MODE_REMOVE: begin
                            state_next = is_empty ? S_RESP : S_SCAN;
                        end
                        MODE_POP: state_next = is_empty ? S_RESP : S_REM_SHIFT;
                        MODE_READ: begin
                            state_next = (is_empty || pos_bad) ? S_RESP : S_READ;
                        end
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_SCAN: begin
                if (walk_done) begin
                    if (!scan_pass) begin
                        state_next = S_RESP;
                    end else begin
                        unique case (mode_reg)
                            MODE_APPEND: state_next = S_PUT;
                            MODE_INSERT: state_next = S_INS_SHIFT;
                            default:     state_next = S_REM_SHIFT;
                        endcase
                    end
                end
            end
            S_INS_SHIFT: begin
                if (walk_done) begin
                    state_next = S_PUT;
                end
            end
            S_REM_SHIFT: begin
                if (walk_done) begin
                    state_next = S_RESP;
                end
            end
            S_PUT:       state_next = S_RESP;
            S_READ:      state_next = S_READ_WAIT;
            S_READ_WAIT: state_next = S_RESP;
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Handshake and RAM port outputs.
    always_comb begin
        s_ready   = (state_reg == S_IDLE);
        res_valid = (state_reg == S_RESP);
        rd_en     = iss_go || (state_reg == S_READ);
        rd_addr   = (state_reg == S_READ) ? pos_ext[AW-1:0] : iss_addr[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = put_idx_reg[AW-1:0];
        wr_data   = rd_data;
        unique case (state_reg)
            S_PUT: begin
                wr_en   = 1'b1;
                wr_data = pid_reg;
            end
            S_INS_SHIFT: begin
                wr_en   = rd_vld_reg;
                wr_addr = rd_idx_inc[AW-1:0];
            end
            S_REM_SHIFT: begin
                wr_en   = rd_vld_reg && (rd_idx_reg != lo_reg);
                wr_addr = rd_idx_dec[AW-1:0];
            end
            default: begin
            end
        endcase
    end

    assign res = '{status: status_reg, pid_out: pid_out_reg, count: COUNT_W'(occ_reg)};

    // Datapath next values.
    always_comb begin
        occ_next     = occ_reg;
        iss_next     = iss_reg;
        lo_next      = lo_reg;
        put_idx_next = put_idx_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        anc_next     = anc_reg;
        anc_idx_next = anc_idx_reg;
        status_next  = status_reg;
        pid_out_next = pid_out_reg;

        // Advance the read walk.
        if (iss_go) begin
            iss_next = (state_reg == S_INS_SHIFT) ? iss_addr : iss_reg + CW'(1);
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    iss_next     = '0;
                    lo_next      = '0;
                    hit_next     = 1'b0;
                    anc_next     = 1'b0;
                    pid_out_next = '0;
                    status_next  = acc_status;
                end
            end
            S_SCAN: begin
                // Compare each returned entry against the id and the anchor.
                if (rd_vld_reg) begin
                    if (rd_data == pid_reg) begin
                        hit_next     = 1'b1;
                        hit_idx_next = rd_idx_reg;
                    end
                    if (rd_data == anchor_reg) begin
                        anc_next     = 1'b1;
                        anc_idx_next = rd_idx_reg;
                    end
                end
                if (walk_done) begin
                    status_next = scan_status;
                    if (scan_pass) begin
                        unique case (mode_reg)
                            MODE_APPEND: begin
                                put_idx_next = occ_reg;
                            end
                            MODE_INSERT: begin
                                lo_next      = anc_idx_inc;
                                iss_next     = occ_reg;
                                put_idx_next = anc_idx_inc;
                            end
                            default: begin
                                lo_next  = hit_idx_reg;
                                iss_next = hit_idx_reg;
                            end
                        endcase
                    end
                end
            end
            S_REM_SHIFT: begin
                // The first entry read is the one being removed.
                if (rd_vld_reg && (rd_idx_reg == lo_reg)) begin
                    pid_out_next = rd_data;
                end
                if (walk_done) begin
                    occ_next    = occ_reg - CW'(1);
                    status_next = ST_OK;
                end
            end
            S_PUT: begin
                occ_next    = occ_reg + CW'(1);
                status_next = ST_OK;
            end
            S_READ_WAIT: begin
                pid_out_next = rd_data;
                status_next  = ST_OK;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            iss_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            iss_reg    <= iss_next;
            rd_vld_reg <= iss_go;
        end
    end

    // Request and working registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg   <= s_mode;
            pid_reg    <= s_pid;
            anchor_reg <= s_anchor_pid;
            pos_reg    <= s_position;
        end
        rd_idx_reg  <= iss_addr;
        lo_reg      <= lo_next;
        put_idx_reg <= put_idx_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        anc_reg     <= anc_next;
        anc_idx_reg <= anc_idx_next;
        status_reg  <= status_next;
        pid_out_reg <= pid_out_next;
    end

    // The count never passes the depth.
    `ASSERT_ALWAYS(a_occ_range, aclk, aresetn, occ_reg <= CW'(DEPTH), "count above depth")
    // Writes land at most one place past the last held entry.
    `ASSERT_IMPLY(a_wr_range, aclk, aresetn, wr_en, CW'(wr_addr) <= occ_reg, "write beyond tail")
    // The walks never read and write the same entry in one cycle.
    `ASSERT_IMPLY(a_no_rw_clash, aclk, aresetn, rd_en && wr_en, rd_addr != wr_addr, "rw clash")
    // A new request starts only with the read pipeline drained.
    `ASSERT_IMPLY(a_drained, aclk, aresetn, accept, !rd_vld_reg, "read pending at accept")

endmodule

/* hw/rtl/ordered_unique_key_queue_top.sv */
// Top level of the ordered unique key queue: sequencer, entry RAM and result register.
//
//   Channel   Direction  Ports
//   request   in         s_valid s_ready s_mode s_pid s_anchor_pid s_position
//   result    out        m_valid m_ready m_status m_pid_out m_count
//
// A request walks the entry RAM's single read port one entry per cycle, once
// for the duplicate and anchor search and once more for the shift that opens
// or closes a gap. Reads do a single RAM read and no walk.
// Reset is synchronous and leaves the queue empty at once, with no clearing pass.
// A finished result waits in the output register; the next request is taken
// as soon as the previous result has moved into that register.
module ordered_unique_key_queue_top
    import oukq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [PID_W-1:0]    s_pid,
    input  logic [PID_W-1:0]    s_anchor_pid,
    input  logic [POS_W-1:0]    s_position,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [PID_W-1:0]    m_pid_out,
    output logic [COUNT_W-1:0]  m_count
);

    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [PID_W-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [PID_W-1:0] wr_data;

    logic             m_valid_reg;
    result_t          m_res_reg;

    oukq_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_pid        (s_pid),
        .s_anchor_pid (s_anchor_pid),
        .s_position   (s_position),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    oukq_ram #(
        .DEPTH (DEPTH),
        .DW    (PID_W),
        .AW    (AW)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The result register takes a new result when empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_res_reg.status;
    assign m_pid_out = m_res_reg.pid_out;
    assign m_count   = m_res_reg.count;

endmodule
